FILE: design/kde_pkg.sv
// Shared types, register map and helper functions of the key debounce event engine.
package kde_pkg;

	localparam int KEY_COUNT   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int EVCNT_W     = 2;
	localparam logic [EVCNT_W-1:0] MAX_EVENTS = 2'd3;

	typedef logic [KEY_COUNT-1:0] keys_t;

	typedef enum logic [1:0] {
		EV_STATUS = 2'd0,
		EV_UP     = 2'd1,
		EV_DOWN   = 2'd2,
		EV_REPEAT = 2'd3
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLDOFF  = 3'd0,
		REG_DEBOUNCE = 3'd1,
		REG_REPEAT   = 3'd2,
		REG_SOURCE   = 3'd3,
		REG_KEY_EN   = 3'd4,
		REG_EVENT_EN = 3'd5,
		REG_IDLE_LVL = 3'd6,
		REG_TOUCH    = 3'd7
	} cfg_index_t;

	localparam int EN_UP     = 0;
	localparam int EN_DOWN   = 1;
	localparam int EN_REPEAT = 2;

	typedef struct packed {
		logic [15:0] holdoff_ms;
		logic [9:0]  debounce_ms;
		logic [9:0]  repeat_ms;
		logic        source_mode;
		keys_t       key_enable_mask;
		logic [2:0]  event_enable;
		logic [23:0] idle_levels;
		logic [7:0]  touched_level;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		holdoff_ms:      16'd0,
		debounce_ms:     10'd70,
		repeat_ms:       10'd25,
		source_mode:     1'b0,
		key_enable_mask: 3'd0,
		event_enable:    3'd0,
		idle_levels:     24'd0,
		touched_level:   8'd0
	};

	// One classified tick: keys to report per event kind, and the pressed mask after it.
	typedef struct packed {
		keys_t up_keys;
		keys_t down_keys;
		keys_t rep_keys;
		keys_t pressed;
	} entry_t;

	function automatic keys_t lowest_bit(input keys_t m);
		return m & (~m + keys_t'(1));
	endfunction

	function automatic logic [1:0] first_index(input keys_t m);
		logic [1:0] idx;
		idx = 2'd0;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = 2'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: design/kde_front.sv
// Front end: debounce, hold-off and repeat timing; classifies each tick into an entry.
module kde_front (
	input  logic           clk,
	input  logic           arst_n,
	input  kde_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  logic [31:0]    now_ms,
	input  logic [2:0]     raw_keys,
	output kde_pkg::entry_t entry
);
	import kde_pkg::*;

	keys_t       cand_keys_q;
	logic        cand_settled_q;
	logic [31:0] cand_time_q;
	keys_t       acc_keys_q;
	logic [31:0] holdoff_start_q;
	logic        holdoff_valid_q;
	logic [31:0] last_event_q;

	logic        holdoff_hit;
	keys_t       sample;
	logic        changed;
	logic [31:0] deb_elapsed;
	logic        settle_now;
	logic        apply;
	logic [9:0]  rep_ivl;
	logic        rep_fire;
	keys_t       new_acc;

	always_comb begin
		holdoff_hit = holdoff_valid_q &&
			((now_ms - holdoff_start_q) <= {16'd0, cfg.holdoff_ms});
		sample      = cfg.source_mode ? lowest_bit(raw_keys & cfg.key_enable_mask) : raw_keys;
		changed     = sample != cand_keys_q;
		deb_elapsed = changed ? 32'd0 : (now_ms - cand_time_q);
		settle_now  = (changed || !cand_settled_q) && (deb_elapsed >= {22'd0, cfg.debounce_ms});
		apply       = !holdoff_hit && settle_now && (sample != acc_keys_q);
		rep_ivl     = (cfg.repeat_ms == 10'd0) ? 10'd1 : cfg.repeat_ms;
		rep_fire    = !holdoff_hit && !apply && cfg.event_enable[EN_REPEAT] &&
			(acc_keys_q != '0) && ((now_ms - last_event_q) >= {22'd0, rep_ivl});
		new_acc     = apply ? sample : acc_keys_q;

		entry.up_keys   = (apply && cfg.event_enable[EN_UP]) ? (acc_keys_q & ~sample) : '0;
		entry.down_keys = (apply && cfg.event_enable[EN_DOWN]) ? (~acc_keys_q & sample) : '0;
		entry.rep_keys  = rep_fire ? acc_keys_q : '0;
		entry.pressed   = new_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_keys_q     <= '0;
			cand_settled_q  <= 1'b0;
			cand_time_q     <= '0;
			acc_keys_q      <= '0;
			holdoff_start_q <= '0;
			holdoff_valid_q <= 1'b0;
			last_event_q    <= '0;
		end else if (in_valid && !holdoff_hit) begin
			cand_keys_q    <= sample;
			cand_settled_q <= settle_now || (!changed && cand_settled_q);
			if (changed) begin
				cand_time_q <= now_ms;
			end
			acc_keys_q <= new_acc;
			if (apply && (sample == '0)) begin
				holdoff_start_q <= now_ms;
				holdoff_valid_q <= 1'b1;
			end
			if (apply || rep_fire) begin
				last_event_q <= now_ms;
			end
		end
	end

endmodule

FILE: design/kde_queue.sv
// Short entry queue between the front end and the result sequencer.
module kde_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  kde_pkg::entry_t wr_entry,
	output logic            q_full,
	input  logic            rd_en,
	output logic            q_avail,
	output kde_pkg::entry_t rd_entry
);
	import kde_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign q_full   = count_q == CNT_W'(QUEUE_DEPTH);
	assign q_avail  = count_q != '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(wr_en) - CNT_W'(rd_en);
		end
	end

endmodule

FILE: design/kde_back.sv
// Result sequencer: expands an entry into event words and a closing status word.
module kde_back (
	input  logic            clk,
	input  logic            arst_n,
	input  kde_pkg::cfg_t   cfg,
	input  logic            q_avail,
	input  kde_pkg::entry_t q_entry,
	output logic            q_rd,
	output logic            empty,
	input  logic            pop,
	output logic [1:0]      event_kind,
	output logic [1:0]      key_index,
	output logic [2:0]      pressed_keys,
	output logic [7:0]      led0_duty,
	output logic [7:0]      led1_duty,
	output logic [7:0]      led2_duty,
	output logic            last_item
);
	import kde_pkg::*;

	entry_t              cur_q;
	logic                cur_valid_q;
	logic [EVCNT_W-1:0]  n_q;

	logic                out_valid_q;
	event_kind_t         out_kind_q;
	logic [1:0]          out_key_q;
	keys_t               out_pressed_q;
	logic [7:0]          out_duty_q [3];
	logic                out_last_q;

	logic                can_emit;
	logic                emit;
	logic                room;
	event_kind_t         sel_kind;
	keys_t               sel_mask;
	entry_t              cur_next;
	logic [7:0]          duty [3];

	always_comb begin
		can_emit = !out_valid_q || pop;
		emit     = can_emit && cur_valid_q;
		room     = n_q != MAX_EVENTS;
		cur_next = cur_q;
		sel_mask = '0;
		priority if (room && (cur_q.up_keys != '0)) begin
			sel_kind         = EV_UP;
			sel_mask         = cur_q.up_keys;
			cur_next.up_keys = cur_q.up_keys & (cur_q.up_keys - keys_t'(1));
		end else if (room && (cur_q.down_keys != '0)) begin
			sel_kind           = EV_DOWN;
			sel_mask           = cur_q.down_keys;
			cur_next.down_keys = cur_q.down_keys & (cur_q.down_keys - keys_t'(1));
		end else if (room && (cur_q.rep_keys != '0)) begin
			sel_kind          = EV_REPEAT;
			sel_mask          = cur_q.rep_keys;
			cur_next.rep_keys = cur_q.rep_keys & (cur_q.rep_keys - keys_t'(1));
		end else begin
			sel_kind = EV_STATUS;
		end
		q_rd = q_avail && (!cur_valid_q || (emit && (sel_kind == EV_STATUS)));
		for (int i = 0; i < 3; i++) begin
			duty[i] = 8'd255 - (cur_q.pressed[i] ? cfg.touched_level : cfg.idle_levels[8*i +: 8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				cur_valid_q <= 1'b1;
				n_q         <= '0;
			end else if (emit) begin
				if (sel_kind == EV_STATUS) begin
					cur_valid_q <= 1'b0;
					n_q         <= '0;
				end else begin
					n_q <= n_q + EVCNT_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_entry;
		end else if (emit) begin
			cur_q <= cur_next;
		end
		if (emit) begin
			out_kind_q    <= sel_kind;
			out_key_q     <= (sel_kind == EV_STATUS) ? 2'd0 : first_index(sel_mask);
			out_pressed_q <= cur_q.pressed;
			out_duty_q    <= duty;
			out_last_q    <= sel_kind == EV_STATUS;
		end
	end

	assign empty        = !out_valid_q;
	assign event_kind   = out_kind_q;
	assign key_index    = out_key_q;
	assign pressed_keys = out_pressed_q;
	assign led0_duty    = out_duty_q[0];
	assign led1_duty    = out_duty_q[1];
	assign led2_duty    = out_duty_q[2];
	assign last_item    = out_last_q;

endmodule

FILE: design/key_debounce_event_engine_top.sv
// Top level of the key debounce event engine: register file, front end, queue and sequencer.
//
// Each word pushed in is one poll tick (timestamp and raw three-key mask). The front end
// takes one tick per cycle while the queue is not full, runs debounce, hold-off and repeat
// timing on it in that same cycle and files the outcome in a two-entry queue; full rises
// only when that queue is full. The sequencer behind it hands out one result word per cycle
// through a single output register while that register is empty or popped: up to three
// event words (key up, then key down, then repeat, lowest key first, extras dropped) and
// always a closing status word with last_item set. A tick thus yields one to four result
// words; its first word passes the queue, the sequencer's entry register and the output
// register. Event and status words carry the pressed mask and LED duties as they stand
// after the tick. Write registers only while the block is drained; there is no read-back.
module key_debounce_event_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [31:0] now_ms,
	input  logic [2:0]  raw_keys,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_kind,
	output logic [1:0]  key_index,
	output logic [2:0]  pressed_keys,
	output logic [7:0]  led0_duty,
	output logic [7:0]  led1_duty,
	output logic [7:0]  led2_duty,
	output logic        last_item
);
	import kde_pkg::*;

	cfg_t   cfg_q;
	entry_t front_entry;
	entry_t q_entry;
	logic   in_valid;
	logic   q_full;
	logic   q_avail;
	logic   q_rd;

	// Register file: take each write in the cycle it arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				REG_HOLDOFF:  cfg_q.holdoff_ms      <= cfg_data[15:0];
				REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data[9:0];
				REG_REPEAT:   cfg_q.repeat_ms       <= cfg_data[9:0];
				REG_SOURCE:   cfg_q.source_mode     <= cfg_data[0];
				REG_KEY_EN:   cfg_q.key_enable_mask <= cfg_data[2:0];
				REG_EVENT_EN: cfg_q.event_enable    <= cfg_data[2:0];
				REG_IDLE_LVL: cfg_q.idle_levels     <= cfg_data;
				REG_TOUCH:    cfg_q.touched_level   <= cfg_data[7:0];
				default:      cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Accept a tick whenever the queue has room.
	assign full     = q_full;
	assign in_valid = push && !q_full;

	kde_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.now_ms   (now_ms),
		.raw_keys (raw_keys),
		.entry    (front_entry)
	);

	kde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_valid),
		.wr_entry (front_entry),
		.q_full   (q_full),
		.rd_en    (q_rd),
		.q_avail  (q_avail),
		.rd_entry (q_entry)
	);

	kde_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_avail      (q_avail),
		.q_entry      (q_entry),
		.q_rd         (q_rd),
		.empty        (empty),
		.pop          (pop),
		.event_kind   (event_kind),
		.key_index    (key_index),
		.pressed_keys (pressed_keys),
		.led0_duty    (led0_duty),
		.led1_duty    (led1_duty),
		.led2_duty    (led2_duty),
		.last_item    (last_item)
	);

endmodule
